// ----- rtl/core/dbbp_pkg.sv -----
// Package for the debounce / blink / bar graph panel.
// Types, register codes, reset values and conversion constants.
// No dependencies.
package dbbp_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned TEMP_W     = 10;
  localparam int unsigned BAR_W      = 5;
  localparam int unsigned PIPE_DEPTH = 5;   // input register plus four conversion stages

  // Configuration register codes
  typedef enum logic [2:0] {
    REG_DEBOUNCE_TICKS  = 3'd0,
    REG_BLINK_PERIOD    = 3'd1,
    REG_SAMPLE_PERIOD   = 3'd2,
    REG_BAR_LEVEL_ONE   = 3'd3,
    REG_BAR_LEVEL_TWO   = 3'd4,
    REG_BAR_LEVEL_THREE = 3'd5,
    REG_BAR_LEVEL_FOUR  = 3'd6,
    REG_BAR_LEVEL_FIVE  = 3'd7
  } reg_idx_e;

  // Reset values of the configuration registers
  localparam logic [7:0]  RST_DEBOUNCE_TICKS = 8'd20;
  localparam logic [15:0] RST_BLINK_PERIOD   = 16'd500;
  localparam logic [15:0] RST_SAMPLE_PERIOD  = 16'd200;
  localparam logic [BAR_W-1:0][SAMPLE_W-1:0] RST_BAR_LEVELS =
    {12'd4000, 12'd3000, 12'd2000, 12'd1000, 12'd100};

  // Temperature conversion constants
  localparam logic [11:0] MV_SCALE   = 12'd3300;   // full scale in millivolts
  localparam int unsigned MV_EXT_W   = 16;         // millivolts, in range for SAMPLE_MAX of 207 or more
  localparam logic [15:0] MV_MID     = 16'd1430;   // millivolts at 25 degrees
  localparam int unsigned DIFF_W     = 12;
  // Beyond this distance above the midpoint the result pins at -512 degrees
  localparam logic [15:0] DIFF_CLAMP = 16'd2310;
  localparam int unsigned N_W        = 15;         // diff * 10
  // floor(n / 43) == (n * DIV43_RECIP) >> DIV43_SHIFT for n below 47662
  localparam logic [14:0] DIV43_RECIP = 15'd24386;
  localparam int unsigned DIV43_SHIFT = 20;
  localparam logic signed [10:0] DEG_MID = 11'sd25;

  typedef struct packed {
    logic [7:0]                      debounce_ticks;
    logic [15:0]                     blink_period;
    logic [15:0]                     sample_period;
    logic [BAR_W-1:0][SAMPLE_W-1:0]  bar_level;
  } cfg_t;

  // Fields that travel beside the conversion pipeline
  typedef struct packed {
    logic                button_level;
    logic                button_fall;
    logic [SAMPLE_W-1:0] pot_sample;
  } side_t;

  typedef struct packed {
    logic                     toggle_led;
    logic                     blink_led;
    logic [BAR_W-1:0]         bar_leds;
    logic signed [TEMP_W-1:0] temperature;
    logic                     sample_taken;
  } res_t;

endpackage

// ----- rtl/core/dbbp_temp_conv.sv -----
// Pipelined temperature conversion: raw sample to whole degrees Celsius.
// Four register stages, one multiplier per stage. Uses dbbp_pkg.
module dbbp_temp_conv #(
  parameter int unsigned SAMPLE_MAX = 4095
) (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic [dbbp_pkg::SAMPLE_W-1:0]      sample_i,
  output logic signed [dbbp_pkg::TEMP_W-1:0] deg_o
);

  localparam int unsigned PROD_W  = 24;   // sample * 3300 fits in 24 bits
  localparam int unsigned RECIP   = (2**PROD_W) / SAMPLE_MAX;
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned MV_MAX  = ((2**dbbp_pkg::SAMPLE_W - 1) * 3300) / SAMPLE_MAX;
  localparam int unsigned MV_W    = $clog2(MV_MAX + 1);
  localparam int unsigned EST_W   = PROD_W + RECIP_W;
  localparam int unsigned Q_W     = dbbp_pkg::TEMP_W;

  logic [PROD_W-1:0]              p_q, p2_q;
  logic [MV_W-1:0]                qe_q;
  logic [dbbp_pkg::DIFF_W-1:0]    diff_q;
  logic                           below_q;
  logic signed [dbbp_pkg::TEMP_W-1:0] deg_q;

  logic [PROD_W-1:0]              p_d;
  logic [EST_W-1:0]               est;
  logic [MV_W-1:0]                qe_d;
  logic [PROD_W-1:0]              back, rem;
  logic [MV_W-1:0]                mv;
  logic [dbbp_pkg::MV_EXT_W-1:0]  mv_ext, hi;
  logic [dbbp_pkg::DIFF_W-1:0]    diff_d;
  logic                           below_d;
  logic [dbbp_pkg::N_W-1:0]       n;
  logic [2*dbbp_pkg::N_W-1:0]     nprod;
  logic [Q_W-1:0]                 q;
  logic signed [Q_W:0]            deg_wide;

  // Stage 1: scale to millivolt numerator
  assign p_d = {{(PROD_W-dbbp_pkg::SAMPLE_W){1'b0}}, sample_i}
             * PROD_W'(dbbp_pkg::MV_SCALE);

  // Stage 2: quotient estimate by reciprocal, low by at most one
  assign est  = EST_W'(p_q) * EST_W'(RECIP);
  assign qe_d = est[PROD_W +: MV_W];

  // Stage 3: correct the estimate, split around the 25 degree point
  always_comb begin
    back    = PROD_W'(qe_q) * PROD_W'(SAMPLE_MAX);
    rem     = p2_q - back;
    mv      = (rem >= PROD_W'(SAMPLE_MAX)) ? qe_q + MV_W'(1) : qe_q;
    mv_ext  = dbbp_pkg::MV_EXT_W'(mv);
    below_d = (mv_ext <= dbbp_pkg::MV_MID);
    hi      = '0;
    if (below_d) begin
      diff_d = dbbp_pkg::DIFF_W'(dbbp_pkg::MV_MID - mv_ext);
    end else begin
      hi     = mv_ext - dbbp_pkg::MV_MID;
      diff_d = (hi > dbbp_pkg::DIFF_CLAMP) ? dbbp_pkg::DIFF_W'(dbbp_pkg::DIFF_CLAMP)
                                           : dbbp_pkg::DIFF_W'(hi);
    end
  end

  // Stage 4: (diff * 10) / 43 and offset from 25 degrees
  always_comb begin
    n        = (dbbp_pkg::N_W'(diff_q) << 3) + (dbbp_pkg::N_W'(diff_q) << 1);
    nprod    = (2*dbbp_pkg::N_W)'(n) * (2*dbbp_pkg::N_W)'(dbbp_pkg::DIV43_RECIP);
    q        = nprod[dbbp_pkg::DIV43_SHIFT +: Q_W];
    deg_wide = below_q ? dbbp_pkg::DEG_MID + $signed({1'b0, q})
                       : dbbp_pkg::DEG_MID - $signed({1'b0, q});
  end

  // Stage registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= p_d;
      p2_q    <= p_q;
      qe_q    <= qe_d;
      diff_q  <= diff_d;
      below_q <= below_d;
      deg_q   <= deg_wide[Q_W-1:0];
    end
  end

  assign deg_o = deg_q;

endmodule

// ----- rtl/core/dbbp_core.sv -----
// Panel state: debounce lockout, blink and sample counters, bar and temperature.
// Updates once per item and holds the result. Uses dbbp_pkg.
module dbbp_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  dbbp_pkg::side_t                    side_i,
  input  logic signed [dbbp_pkg::TEMP_W-1:0] deg_i,
  input  dbbp_pkg::cfg_t                     cfg_i,
  output dbbp_pkg::res_t                     res_o,
  output logic                               pending_o
);

  logic        pending_q, pending_d;
  logic [7:0]  dcnt_q, dcnt_d, dcnt_inc;
  logic        toggle_q, toggle_d;
  logic [15:0] bcnt_q, bcnt_d, bcnt_inc;
  logic        blink_q, blink_d;
  logic [15:0] scnt_q, scnt_d, scnt_inc;
  logic [dbbp_pkg::BAR_W-1:0]         bar_q, bar_d;
  logic signed [dbbp_pkg::TEMP_W-1:0] temp_q, temp_d;
  logic        taken_q, taken_d;

  // Debounce: count while locked out, re-read the pin when the delay ends
  always_comb begin
    pending_d = pending_q;
    dcnt_d    = dcnt_q;
    toggle_d  = toggle_q;
    dcnt_inc  = (dcnt_q != 8'hFF) ? dcnt_q + 8'd1 : dcnt_q;
    if (pending_q) begin
      dcnt_d = dcnt_inc;
      if (dcnt_inc >= cfg_i.debounce_ticks) begin
        toggle_d  = toggle_q ^ ~side_i.button_level;
        pending_d = 1'b0;
      end
    end else if (side_i.button_fall) begin
      pending_d = 1'b1;
      dcnt_d    = 8'd0;
    end
  end

  // Blink counter
  always_comb begin
    bcnt_inc = bcnt_q + 16'd1;
    blink_d  = blink_q;
    bcnt_d   = bcnt_inc;
    if (bcnt_inc >= cfg_i.blink_period) begin
      blink_d = ~blink_q;
      bcnt_d  = 16'd0;
    end
  end

  // Sample counter, bar thresholds and temperature capture
  always_comb begin
    scnt_inc = scnt_q + 16'd1;
    scnt_d   = scnt_inc;
    bar_d    = bar_q;
    temp_d   = temp_q;
    taken_d  = 1'b0;
    if (scnt_inc >= cfg_i.sample_period) begin
      scnt_d  = 16'd0;
      taken_d = 1'b1;
      temp_d  = deg_i;
      for (int i = 0; i < dbbp_pkg::BAR_W; i++) begin
        bar_d[i] = (side_i.pot_sample > cfg_i.bar_level[i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      dcnt_q    <= 8'd0;
      toggle_q  <= 1'b0;
      bcnt_q    <= 16'd0;
      blink_q   <= 1'b1;
      scnt_q    <= 16'd0;
      bar_q     <= '0;
      temp_q    <= '0;
      taken_q   <= 1'b0;
    end else if (en_i) begin
      pending_q <= pending_d;
      dcnt_q    <= dcnt_d;
      toggle_q  <= toggle_d;
      bcnt_q    <= bcnt_d;
      blink_q   <= blink_d;
      scnt_q    <= scnt_d;
      bar_q     <= bar_d;
      temp_q    <= temp_d;
      taken_q   <= taken_d;
    end
  end

  assign res_o.toggle_led   = toggle_q;
  assign res_o.blink_led    = blink_q;
  assign res_o.bar_leds     = bar_q;
  assign res_o.temperature  = temp_q;
  assign res_o.sample_taken = taken_q;
  assign pending_o          = pending_q;

endmodule

// ----- rtl/core/debounce_blink_bargraph_panel_top.sv -----
// Top level of the debounce / blink / bar graph panel.
// Depends on dbbp_pkg, dbbp_temp_conv and dbbp_core.
//
//  channel  | direction | carries
//  ---------+-----------+----------------------------------------------
//  s_axis   | in        | one millisecond tick: button, edge, two samples
//  m_axis   | out       | LEDs, bar, temperature, sample flag per tick
//  cfg      | in        | register writes, index 0..7, no read-back
//
// One item per cycle sustained while m_axis is not stalled. An accepted item
// passes the input register, four conversion stages (one multiplier each)
// and the state/result register, in that order. A stall on m_axis freezes
// the whole pipeline; s_axis_tready_o is high whenever the result register
// is empty or being drained. Reset clears the valid flags and panel state and
// loads register defaults; the input and conversion data are not reset.
module debounce_blink_bargraph_panel_top #(
  parameter int unsigned SAMPLE_MAX = 4095
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [0] button_level, [1] button_fall, [13:2] pot_sample, [25:14] temp_sample
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [0] toggle_led, [1] blink_led, [6:2] bar_leds, [16:7] temperature,
  // [17] sample_taken
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam int unsigned DEPTH = dbbp_pkg::PIPE_DEPTH;

  logic                          advance;
  logic                          core_en;
  logic [DEPTH-1:0]              vld_q;
  dbbp_pkg::side_t               side_q [DEPTH];
  logic [dbbp_pkg::SAMPLE_W-1:0] temp_raw_q;
  logic                          out_vld_q;
  dbbp_pkg::cfg_t                cfg_q;
  dbbp_pkg::res_t                res;
  logic                          pending;
  logic signed [dbbp_pkg::TEMP_W-1:0] deg;

  // Pipeline moves as a whole unless the result is stalled
  assign advance         = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;
  assign core_en         = advance && vld_q[DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      vld_q     <= {vld_q[DEPTH-2:0], s_axis_tvalid_i};
      out_vld_q <= vld_q[DEPTH-1];
    end
  end

  // Input register and side fields kept in step with the conversion
  always_ff @(posedge clk_i) begin
    if (advance) begin
      side_q[0].button_level <= s_axis_tdata_i[0];
      side_q[0].button_fall  <= s_axis_tdata_i[1];
      side_q[0].pot_sample   <= s_axis_tdata_i[13:2];
      temp_raw_q             <= s_axis_tdata_i[25:14];
      for (int i = 1; i < DEPTH; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks <= dbbp_pkg::RST_DEBOUNCE_TICKS;
      cfg_q.blink_period   <= dbbp_pkg::RST_BLINK_PERIOD;
      cfg_q.sample_period  <= dbbp_pkg::RST_SAMPLE_PERIOD;
      cfg_q.bar_level      <= dbbp_pkg::RST_BAR_LEVELS;
    end else if (cfg_we_i) begin
      unique case (dbbp_pkg::reg_idx_e'(cfg_idx_i))
        dbbp_pkg::REG_DEBOUNCE_TICKS:  cfg_q.debounce_ticks <= cfg_data_i[7:0];
        dbbp_pkg::REG_BLINK_PERIOD:    cfg_q.blink_period   <= cfg_data_i;
        dbbp_pkg::REG_SAMPLE_PERIOD:   cfg_q.sample_period  <= cfg_data_i;
        dbbp_pkg::REG_BAR_LEVEL_ONE:   cfg_q.bar_level[0]   <= cfg_data_i[11:0];
        dbbp_pkg::REG_BAR_LEVEL_TWO:   cfg_q.bar_level[1]   <= cfg_data_i[11:0];
        dbbp_pkg::REG_BAR_LEVEL_THREE: cfg_q.bar_level[2]   <= cfg_data_i[11:0];
        dbbp_pkg::REG_BAR_LEVEL_FOUR:  cfg_q.bar_level[3]   <= cfg_data_i[11:0];
        dbbp_pkg::REG_BAR_LEVEL_FIVE:  cfg_q.bar_level[4]   <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  dbbp_temp_conv #(
    .SAMPLE_MAX(SAMPLE_MAX)
  ) u_temp_conv (
    .clk_i   (clk_i),
    .en_i    (advance),
    .sample_i(temp_raw_q),
    .deg_o   (deg)
  );

  dbbp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (core_en),
    .side_i   (side_q[DEPTH-1]),
    .deg_i    (deg),
    .cfg_i    (cfg_q),
    .res_o    (res),
    .pending_o(pending)
  );

  // Result packing
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, res.sample_taken, res.temperature, res.bar_leds,
                            res.blink_led, res.toggle_led};

  // Toggle LED only flips on an update that ends a lockout
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(m_axis_tdata_o[0]) |-> $past(core_en && pending))
    else $error("toggle_led changed outside a debounce decision");

  // Result fields change only on a state update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(m_axis_tdata_o) |-> $past(core_en))
    else $error("result changed without an item reaching the state stage");

  // A stalled result freezes the conversion pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(vld_q))
    else $error("pipeline moved while the result was stalled");

endmodule

// ----- dv/debounce_blink_bargraph_panel_top_tb.sv -----
// Testbench for debounce_blink_bargraph_panel_top: random and directed ticks with
// random stalls on both streams, each result checked against an in-bench panel model.
// Depends on dbbp_pkg and the RTL of the panel top level.
module debounce_blink_bargraph_panel_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ADC_FULL    = 4095;    // matches the DUT default SAMPLE_MAX
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_HOLD   = 400;     // receiver hold-off, in cycles
  localparam int unsigned HOLD_AT     = 150;     // result count that starts the hold-off

  // One millisecond tick, packed as it travels on s_axis tdata (highest field first)
  typedef struct packed {
    logic [11:0] temp_sample;
    logic [11:0] pot_sample;
    logic        button_fall;
    logic        button_level;
  } tick_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  debounce_blink_bargraph_panel_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Panel model: shadow registers and state
  dbbp_pkg::cfg_t     panel_cfg;
  bit                 dbn_pending;
  logic [7:0]         dbn_count;
  bit                 toggle_q;
  logic [15:0]        blink_cnt;
  bit                 blink_q;
  logic [15:0]        smp_cnt;
  logic [4:0]         bar_q;
  logic signed [9:0]  degrees_q;

  tick_t          tick_q[$];      // ticks waiting to be offered
  dbbp_pkg::res_t panel_q[$];     // expected panel outputs, oldest first

  tick_t cur_tick;
  bit    offering;
  bit    ready_nxt;
  int    send_gap;
  int    recv_wait;
  int    hold_left;
  bit    hold_done;
  bit    snd_idle_on;
  bit    rcv_idle_on;
  int    press_left;

  int    ticks_sent;
  int    results_seen;
  int    mismatches;
  int    settings_loaded;
  int    sample_updates;
  int    toggle_flips;
  int    blink_flips;
  int    cycle_cnt;

  // Whole degrees from a raw sensor reading, integer only, saturated to 10 bits
  function automatic logic signed [9:0] degrees_of(logic [11:0] raw);
    int unsigned mv;
    int unsigned drop;
    int          t;
    mv = (int'(raw) * 3300) / ADC_FULL;
    if (mv <= 1430) begin
      t = 25 + int'(((1430 - mv) * 10) / 43);
    end else begin
      drop = ((mv - 1430) * 10) / 43;
      if (drop > 1000) drop = 1000;
      t = 25 - int'(drop);
    end
    if (t > 511) t = 511;
    if (t < -512) t = -512;
    return t[9:0];
  endfunction

  // Advance the panel by one tick and queue the outputs it should show
  function automatic void advance_panel(tick_t tk);
    dbbp_pkg::res_t r;
    bit             taken;
    taken = 1'b0;
    if (dbn_pending) begin
      if (dbn_count < 8'd255) dbn_count = dbn_count + 8'd1;
      if (dbn_count >= panel_cfg.debounce_ticks) begin
        if (!tk.button_level) begin
          toggle_q = ~toggle_q;
          toggle_flips++;
        end
        dbn_pending = 1'b0;
      end
    end else if (tk.button_fall) begin
      dbn_pending = 1'b1;
      dbn_count   = '0;
    end

    blink_cnt = blink_cnt + 16'd1;
    if (blink_cnt >= panel_cfg.blink_period) begin
      blink_q   = ~blink_q;
      blink_cnt = '0;
      blink_flips++;
    end

    smp_cnt = smp_cnt + 16'd1;
    if (smp_cnt >= panel_cfg.sample_period) begin
      smp_cnt = '0;
      taken   = 1'b1;
      for (int i = 0; i < 5; i++) begin
        bar_q[i] = tk.pot_sample > panel_cfg.bar_level[i];
      end
      degrees_q = degrees_of(tk.temp_sample);
      sample_updates++;
    end

    r.toggle_led   = toggle_q;
    r.blink_led    = blink_q;
    r.bar_leds     = bar_q;
    r.temperature  = degrees_q;
    r.sample_taken = taken;
    panel_q.push_back(r);
  endfunction

  // Compare one accepted result with the oldest expectation
  function automatic void check_result(logic [23:0] d);
    dbbp_pkg::res_t e;
    if (panel_q.size() == 0) begin
      $error("unexpected result %h with no tick outstanding", d);
      mismatches++;
      return;
    end
    e = panel_q.pop_front();
    if (d[0] !== e.toggle_led) begin
      $error("toggle_led: expected %0d, got %0d", e.toggle_led, d[0]);
      mismatches++;
    end
    if (d[1] !== e.blink_led) begin
      $error("blink_led: expected %0d, got %0d", e.blink_led, d[1]);
      mismatches++;
    end
    if (d[6:2] !== e.bar_leds) begin
      $error("bar_leds: expected %b, got %b", e.bar_leds, d[6:2]);
      mismatches++;
    end
    if (d[16:7] !== e.temperature) begin
      $error("temperature: expected %0d, got %0d", e.temperature, $signed(d[16:7]));
      mismatches++;
    end
    if (d[17] !== e.sample_taken) begin
      $error("sample_taken: expected %0d, got %0d", e.sample_taken, d[17]);
      mismatches++;
    end
  endfunction

  function automatic int idle_draw(bit on);
    return on ? int'($urandom_range(0, 19)) : 0;
  endfunction

  // Button model: mostly clean presses of random length with some bounce,
  // plus stray edges while released
  function automatic tick_t random_tick();
    tick_t tk;
    tk.pot_sample   = 12'($urandom_range(0, 4095));
    tk.temp_sample  = 12'($urandom_range(0, 4095));
    tk.button_level = 1'b1;
    tk.button_fall  = 1'b0;
    if (press_left > 0) begin
      press_left      = press_left - 1;
      tk.button_level = 1'b0;
      tk.button_fall  = ($urandom_range(0, 9) == 0);
    end else if ($urandom_range(0, 7) == 0) begin
      press_left      = $urandom_range(0, 24);
      tk.button_level = 1'b0;
      tk.button_fall  = 1'b1;
    end else if ($urandom_range(0, 19) == 0) begin
      tk.button_fall  = 1'b1;
      tk.button_level = 1'($urandom_range(0, 1));
    end
    return tk;
  endfunction

  function automatic void push_tick(bit lvl, bit fall, int pot, int temp);
    tick_t tk;
    tk.button_level = lvl;
    tk.button_fall  = fall;
    tk.pot_sample   = 12'(pot);
    tk.temp_sample  = 12'(temp);
    tick_q.push_back(tk);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run-length guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Tick driver: offers queued ticks, draws a gap after each accepted one
  always @(posedge clk_i) begin
    if (rst_ni) begin
      offering = s_axis_tvalid_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        advance_panel(cur_tick);
        ticks_sent++;
        offering = 1'b0;
        send_gap = idle_draw(snd_idle_on);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (tick_q.size() > 0) begin
          cur_tick = tick_q.pop_front();
          offering = 1'b1;
        end
      end
      s_axis_tvalid_i <= offering;
      s_axis_tdata_i  <= {6'b0, cur_tick};
    end
  end

  // Result monitor: checks each accepted result, stalls at random, and holds
  // off once for a long stretch so the pipeline backs up into s_axis
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        check_result(m_axis_tdata_o);
        results_seen++;
        recv_wait = idle_draw(rcv_idle_on);
        if (!hold_done && results_seen == HOLD_AT) begin
          hold_left = LONG_HOLD;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        ready_nxt = 1'b0;
      end else begin
        ready_nxt = 1'b1;
      end
      m_axis_tready_i <= ready_nxt;
    end
  end

  // Register write, mirrored into the shadow configuration
  task automatic cfg_write(dbbp_pkg::reg_idx_e idx, logic [15:0] val);
    logic [2:0] lvl_sel;
    lvl_sel = 3'(idx - dbbp_pkg::REG_BAR_LEVEL_ONE);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      dbbp_pkg::REG_DEBOUNCE_TICKS: panel_cfg.debounce_ticks = val[7:0];
      dbbp_pkg::REG_BLINK_PERIOD:   panel_cfg.blink_period   = val;
      dbbp_pkg::REG_SAMPLE_PERIOD:  panel_cfg.sample_period  = val;
      default:                      panel_cfg.bar_level[lvl_sel] = val[11:0];
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_loaded++;
  endtask

  task automatic cfg_levels(int l1, int l2, int l3, int l4, int l5);
    cfg_write(dbbp_pkg::REG_BAR_LEVEL_ONE, 16'(l1));
    cfg_write(dbbp_pkg::REG_BAR_LEVEL_TWO, 16'(l2));
    cfg_write(dbbp_pkg::REG_BAR_LEVEL_THREE, 16'(l3));
    cfg_write(dbbp_pkg::REG_BAR_LEVEL_FOUR, 16'(l4));
    cfg_write(dbbp_pkg::REG_BAR_LEVEL_FIVE, 16'(l5));
  endtask

  // Wait until every queued tick is in and every result is out
  task automatic wait_drained();
    while (tick_q.size() != 0 || offering || panel_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic random_settings(bit extreme);
    logic [15:0] lvl;
    if (extreme) begin
      cfg_write(dbbp_pkg::REG_DEBOUNCE_TICKS, {8'($urandom_range(0, 255)), 8'd255});
      cfg_write(dbbp_pkg::REG_BLINK_PERIOD, 16'hFFFF);
      cfg_write(dbbp_pkg::REG_SAMPLE_PERIOD, 16'hFFFF);
    end else begin
      cfg_write(dbbp_pkg::REG_DEBOUNCE_TICKS,
                {8'($urandom_range(0, 255)), 8'($urandom_range(0, 12))});
      cfg_write(dbbp_pkg::REG_BLINK_PERIOD, 16'($urandom_range(0, 15)));
      cfg_write(dbbp_pkg::REG_SAMPLE_PERIOD, 16'($urandom_range(0, 9)));
    end
    // Ascending thresholds most of the time, fully random otherwise;
    // the upper data bits are don't-care for a 12-bit register
    for (int i = 0; i < 5; i++) begin
      if ($urandom_range(0, 2) == 0) lvl[11:0] = 12'($urandom_range(0, 4095));
      else lvl[11:0] = 12'(i * 800 + int'($urandom_range(0, 899)));
      lvl[15:12] = 4'($urandom_range(0, 15));
      cfg_write(dbbp_pkg::reg_idx_e'(dbbp_pkg::REG_BAR_LEVEL_ONE + i), lvl);
    end
    cfg_done();
  endtask

  task automatic random_phase(int n, bit snd_idle, bit rcv_idle);
    snd_idle_on = snd_idle;
    rcv_idle_on = rcv_idle;
    for (int i = 0; i < n; i++) tick_q.push_back(random_tick());
    wait_drained();
  endtask

  // Stimulus and end of run
  initial begin
    // Panel model at reset
    panel_cfg.debounce_ticks = 8'd20;
    panel_cfg.blink_period   = 16'd500;
    panel_cfg.sample_period  = 16'd200;
    panel_cfg.bar_level[0]   = 12'd100;
    panel_cfg.bar_level[1]   = 12'd1000;
    panel_cfg.bar_level[2]   = 12'd2000;
    panel_cfg.bar_level[3]   = 12'd3000;
    panel_cfg.bar_level[4]   = 12'd4000;
    dbn_pending = 1'b0;
    dbn_count   = '0;
    toggle_q    = 1'b0;
    blink_cnt   = '0;
    blink_q     = 1'b1;
    smp_cnt     = '0;
    bar_q       = '0;
    degrees_q   = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults, sender back to back, receiver stalling plus one long hold
    random_phase(180, 1'b0, 1'b1);

    // Directed: short delays, sample every tick, default thresholds
    cfg_write(dbbp_pkg::REG_DEBOUNCE_TICKS, 16'd2);
    cfg_write(dbbp_pkg::REG_BLINK_PERIOD, 16'd3);
    cfg_write(dbbp_pkg::REG_SAMPLE_PERIOD, 16'd1);
    cfg_levels(100, 1000, 2000, 3000, 4000);
    cfg_done();
    push_tick(0, 1, 0, 0);         // edge while idle arms the lockout
    push_tick(0, 1, 100, 4095);    // edge during lockout is ignored
    push_tick(0, 1, 101, 1774);    // read low: toggle; edge on the closing tick ignored
    push_tick(1, 1, 1000, 1775);   // new edge arms again
    push_tick(0, 0, 1001, 1776);
    push_tick(1, 0, 2000, 2048);   // read high: no toggle
    push_tick(1, 0, 2001, 4094);
    push_tick(0, 0, 3000, 1);
    push_tick(0, 0, 3001, 2);
    push_tick(1, 0, 4000, 3000);
    push_tick(0, 0, 4001, 1000);
    push_tick(1, 0, 4095, 4095);
    push_tick(1, 1, 4095, 0);
    push_tick(0, 0, 2500, 1430);
    random_phase(0, 1'b1, 1'b1);

    // Directed: zero delay, zero periods that fire every tick, edge thresholds
    cfg_write(dbbp_pkg::REG_DEBOUNCE_TICKS, 16'd0);
    cfg_write(dbbp_pkg::REG_BLINK_PERIOD, 16'd0);
    cfg_write(dbbp_pkg::REG_SAMPLE_PERIOD, 16'd0);
    cfg_levels(0, 1, 2048, 4094, 4095);
    cfg_done();
    push_tick(0, 1, 0, 1774);
    push_tick(0, 1, 1, 1775);
    push_tick(1, 1, 2, 3300);
    push_tick(1, 0, 2049, 123);
    push_tick(0, 0, 4094, 2222);
    push_tick(1, 0, 4095, 4095);
    random_phase(0, 1'b0, 1'b0);

    // Random settings, largest delays and periods in one phase
    random_settings(1'b0);
    random_phase(40, 1'b1, 1'b0);
    random_settings(1'b1);
    random_phase(300, 1'b1, 1'b1);
    random_settings(1'b0);
    random_phase(40, 1'b0, 1'b0);
    random_settings(1'b0);
    random_phase(40, 1'b1, 1'b1);

    // Let anything stray come out of the pipeline
    repeat (20) @(posedge clk_i);

    $display("Checked %0d ticks over %0d register settings and reset defaults:",
             ticks_sent, settings_loaded);
    $display("%0d sample updates, %0d toggle flips, %0d blink flips.",
             sample_updates, toggle_flips, blink_flips);
    if (mismatches == 0 && panel_q.size() == 0 && results_seen == ticks_sent) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- debounce_blink_bargraph_panel_top.f -----
rtl/core/dbbp_pkg.sv
rtl/core/dbbp_temp_conv.sv
rtl/core/dbbp_core.sv
rtl/core/debounce_blink_bargraph_panel_top.sv
dv/debounce_blink_bargraph_panel_top_tb.sv
